/* rtl/core/smx_pkg.sv */
// Package for the SplitMix64 keystream XOR stream decoder.
// Holds the shared types, register indexes, status codes and generator constants.
// Used by every module of the decoder.
package smx_pkg;

  // Golden-ratio increment and finaliser constants of SplitMix64.
  localparam logic [63:0] SM_INCREMENT = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SM_MUL_A     = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] SM_MUL_B     = 64'h94D049BB133111EB;
  localparam int unsigned SM_SHIFT_1   = 30;
  localparam int unsigned SM_SHIFT_2   = 27;
  localparam int unsigned SM_SHIFT_3   = 31;

  // Default depth of the queue between front and back.
  localparam int unsigned FIFO_DEPTH = 4;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_SEED       = 2'd0,
    CFG_ENCRYPTED_MODE = 2'd1,
    CFG_BLOB_LENGTH    = 2'd2,
    CFG_STORED_LENGTH  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_TRUNCATED   = 2'd1,
    ST_KEY_MISSING = 2'd2,
    ST_EMPTY       = 2'd3
  } status_e;

  typedef struct packed {
    logic [63:0] key_seed;
    logic        encrypted_mode;
    logic [31:0] blob_length;
    logic [31:0] stored_length;
  } cfg_t;

  // Classified byte as it travels from front to back.
  typedef struct packed {
    logic [7:0] in_byte;
    logic [2:0] lane;
    logic       last;
    status_e    status;
    logic       need_word;
  } tag_t;

  typedef enum logic [1:0] {
    MX_IDLE,
    MX_MUL_A,
    MX_MUL_B
  } mix_state_e;

  typedef enum logic {
    BK_RUN,
    BK_WAIT
  } back_state_e;

endpackage

/* rtl/core/smx_ifs.sv */
// Valid/ready channel interfaces of the SplitMix64 stream decoder.
// smx_in_if carries stored bytes in, smx_out_if carries decoded results out.
// No dependencies.
interface smx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface smx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       blob_end;
  logic [1:0] status;

  modport source (output valid, output out_byte, output blob_end, output status, input ready);
  modport sink   (input valid, input out_byte, input blob_end, input status, output ready);
endinterface

/* rtl/core/smx_front.sv */
// Front end of the stream decoder: accepts bytes and classifies them.
// Tracks the position in the blob and works out lane, last flag and status.
// Depends on smx_pkg and smx_in_if.
module smx_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smx_pkg::cfg_t       cfg_i,
  input  logic                restart_i,
  smx_in_if.sink              in_i,
  input  logic                full_i,
  output logic                push_o,
  output smx_pkg::tag_t       tag_o
);

  logic [31:0]      pos_q, pos_d;
  logic [32:0]      pos_inc;
  logic             blob_empty;
  logic             last;
  smx_pkg::status_e status;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  assign blob_empty = (cfg_i.blob_length == 32'd0);
  assign pos_inc    = {1'b0, pos_q} + 33'd1;
  assign last       = blob_empty || (pos_inc >= {1'b0, cfg_i.blob_length});

  always_comb begin
    if (cfg_i.stored_length < cfg_i.blob_length) begin
      status = smx_pkg::ST_TRUNCATED;
    end else if (cfg_i.encrypted_mode && (cfg_i.key_seed == 64'd0)) begin
      status = smx_pkg::ST_KEY_MISSING;
    end else if (blob_empty) begin
      status = smx_pkg::ST_EMPTY;
    end else begin
      status = smx_pkg::ST_OK;
    end
  end

  // Only bytes that actually use the keystream ask the back for a fresh word.
  // Status and mode cannot change inside a blob, so the generator needs to move
  // only for these.
  always_comb begin
    tag_o.in_byte   = in_i.in_byte;
    tag_o.lane      = pos_q[2:0];
    tag_o.last      = last;
    tag_o.status    = status;
    tag_o.need_word = (pos_q[2:0] == 3'd0) && !blob_empty && cfg_i.encrypted_mode &&
                      (status == smx_pkg::ST_OK);
  end

  always_comb begin
    pos_d = pos_q;
    if (restart_i) begin
      pos_d = '0;
    end else if (push_o) begin
      pos_d = last ? 32'd0 : pos_inc[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

/* rtl/core/smx_queue.sv */
// Short queue of classified bytes between the front and the back.
// Lets either side stall on its own.
// Depends on smx_pkg.
module smx_queue #(
  parameter int unsigned Depth = smx_pkg::FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  smx_pkg::tag_t tag_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output smx_pkg::tag_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  smx_pkg::tag_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= tag_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q != CntW'(Depth))
    else $error("queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue read while empty");

endmodule

/* rtl/core/smx_mix.sv */
// SplitMix64 finaliser as an iterative unit around one 32x32 multiplier.
// Each 64-bit multiply sums its 32x32 partial products one after another.
// Depends on smx_pkg.
module smx_mix (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] state_i,
  output logic        done_o,
  output logic [63:0] word_o
);

  localparam logic [1:0] KLast = 2'd3;

  smx_pkg::mix_state_e st_q, st_d;
  logic [1:0]  k_q, k_d;
  logic [63:0] x_q, x_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] word_q, word_d;
  logic        done_q, done_d;
  logic [63:0] mul_const;
  logic [31:0] op_a, op_b;
  logic [63:0] term;
  logic [63:0] acc_sum;

  // Low 64 bits of x * C: lo*lo, plus the low halves of both cross products
  // shifted up by 32. The high*high product falls out entirely.
  assign mul_const = (st_q == smx_pkg::MX_MUL_A) ? smx_pkg::SM_MUL_A : smx_pkg::SM_MUL_B;

  always_comb begin
    case (k_q)
      2'd0: begin
        op_a = x_q[31:0];
        op_b = mul_const[31:0];
      end
      2'd1: begin
        op_a = x_q[63:32];
        op_b = mul_const[31:0];
      end
      default: begin
        op_a = x_q[31:0];
        op_b = mul_const[63:32];
      end
    endcase
  end

  assign prod_d  = op_a * op_b;
  assign term    = (k_q == 2'd1) ? prod_q : {prod_q[31:0], 32'h0};
  assign acc_sum = acc_q + term;

  always_comb begin
    st_d = st_q;
    case (st_q)
      smx_pkg::MX_IDLE: begin
        if (start_i) begin
          st_d = smx_pkg::MX_MUL_A;
        end
      end
      smx_pkg::MX_MUL_A: begin
        if (k_q == KLast) begin
          st_d = smx_pkg::MX_MUL_B;
        end
      end
      smx_pkg::MX_MUL_B: begin
        if (k_q == KLast) begin
          st_d = smx_pkg::MX_IDLE;
        end
      end
      default: st_d = smx_pkg::MX_IDLE;
    endcase
  end

  assign k_d = ((st_q == smx_pkg::MX_IDLE) || (k_q == KLast)) ? 2'd0 : k_q + 2'd1;

  always_comb begin
    x_d    = x_q;
    acc_d  = acc_q;
    word_d = word_q;
    done_d = 1'b0;
    case (st_q)
      smx_pkg::MX_IDLE: begin
        if (start_i) begin
          x_d   = state_i ^ (state_i >> smx_pkg::SM_SHIFT_1);
          acc_d = '0;
        end
      end
      smx_pkg::MX_MUL_A: begin
        if (k_q != 2'd0) begin
          acc_d = acc_sum;
        end
        if (k_q == KLast) begin
          x_d   = acc_sum ^ (acc_sum >> smx_pkg::SM_SHIFT_2);
          acc_d = '0;
        end
      end
      smx_pkg::MX_MUL_B: begin
        if (k_q != 2'd0) begin
          acc_d = acc_sum;
        end
        if (k_q == KLast) begin
          word_d = acc_sum ^ (acc_sum >> smx_pkg::SM_SHIFT_3);
          done_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign word_o = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= smx_pkg::MX_IDLE;
      k_q    <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      k_q    <= k_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    word_q <= word_d;
  end

  a_done_after_mul_b : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(st_q == smx_pkg::MX_MUL_B))
    else $error("keystream word finished outside the second multiply");

endmodule

/* rtl/core/smx_back.sv */
// Back end of the stream decoder: generator state, keystream and output register.
// Takes classified bytes from the queue and XORs in the keystream when encrypted.
// Depends on smx_pkg, smx_out_if and smx_mix.
module smx_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  smx_pkg::cfg_t cfg_i,
  input  logic          restart_i,
  input  logic          head_valid_i,
  input  smx_pkg::tag_t head_i,
  output logic          pop_o,
  smx_out_if.source     out_o
);

  smx_pkg::back_state_e st_q, st_d;
  logic [63:0] gen_q, gen_d;
  logic [63:0] gen_next;
  logic        fresh_q, fresh_d;
  logic        mix_start;
  logic        mix_done;
  logic [63:0] mix_word;
  logic [63:0] key_shift;
  logic [7:0]  dec_byte;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        blob_end_q, blob_end_d;
  logic [1:0]  status_q, status_d;

  assign gen_next  = gen_q + smx_pkg::SM_INCREMENT;
  assign mix_start = (st_q == smx_pkg::BK_RUN) && head_valid_i && head_i.need_word && !fresh_q;
  assign pop_o     = head_valid_i && (!head_i.need_word || fresh_q) &&
                     (!out_valid_q || out_o.ready);

  smx_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mix_start),
    .state_i (gen_next),
    .done_o  (mix_done),
    .word_o  (mix_word)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      smx_pkg::BK_RUN: begin
        if (mix_start) begin
          st_d = smx_pkg::BK_WAIT;
        end
      end
      smx_pkg::BK_WAIT: begin
        if (mix_done) begin
          st_d = smx_pkg::BK_RUN;
        end
      end
      default: st_d = smx_pkg::BK_RUN;
    endcase
  end

  always_comb begin
    gen_d   = gen_q;
    fresh_d = fresh_q;
    if (restart_i) begin
      gen_d   = cfg_i.key_seed;
      fresh_d = 1'b0;
    end else begin
      if (mix_start) begin
        gen_d = gen_next;
      end
      if (mix_done) begin
        fresh_d = 1'b1;
      end
      if (pop_o && head_i.need_word) begin
        fresh_d = 1'b0;
      end
      if (pop_o && head_i.last) begin
        gen_d = cfg_i.key_seed;
      end
    end
  end

  assign key_shift = mix_word >> {head_i.lane, 3'b000};

  always_comb begin
    if (head_i.status != smx_pkg::ST_OK) begin
      dec_byte = 8'h00;
    end else if (cfg_i.encrypted_mode) begin
      dec_byte = head_i.in_byte ^ key_shift[7:0];
    end else begin
      dec_byte = head_i.in_byte;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    blob_end_d  = blob_end_q;
    status_d    = status_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      out_byte_d  = dec_byte;
      blob_end_d  = head_i.last;
      status_d    = head_i.status;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.blob_end = blob_end_q;
  assign out_o.status   = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= smx_pkg::BK_RUN;
      gen_q       <= '0;
      fresh_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      gen_q       <= gen_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    blob_end_q <= blob_end_d;
    status_q   <= status_d;
  end

  a_word_ready_on_use : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && head_i.need_word |-> fresh_q && (st_q == smx_pkg::BK_RUN))
    else $error("byte left the queue before its keystream word was ready");

endmodule

/* rtl/core/splitmix64_xor_stream_decoder.sv */
// Decodes a blob byte stream, XORing each byte with a SplitMix64 keystream when
// encrypted mode is set. Results come out in input order, one per byte. In plain
// mode, or while the status is not ok, bytes can be taken one per cycle while the
// receiver is ready, and each result passes the queue and the output register.
// In encrypted mode the byte that opens each keystream word waits while the word
// is built by an iterative unit around a single 32x32 multiplier; the other bytes
// of that word then follow one per cycle as in plain mode. Any configuration write
// restarts the blob; write registers only while the block is idle.
// Depends on smx_pkg, smx_ifs, smx_front, smx_queue and smx_back.
module splitmix64_xor_stream_decoder #(
  parameter int unsigned FifoDepth = smx_pkg::FIFO_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  smx_in_if.sink                          in_i,
  smx_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [smx_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [smx_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  smx_pkg::cfg_t cfg_q, cfg_d;
  logic          restart_q;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  smx_pkg::tag_t tag_in;
  smx_pkg::tag_t tag_head;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (smx_pkg::cfg_idx_e'(cfg_idx_i))
        smx_pkg::CFG_KEY_SEED:       cfg_d.key_seed       = cfg_wdata_i;
        smx_pkg::CFG_ENCRYPTED_MODE: cfg_d.encrypted_mode = cfg_wdata_i[0];
        smx_pkg::CFG_BLOB_LENGTH:    cfg_d.blob_length    = cfg_wdata_i[31:0];
        smx_pkg::CFG_STORED_LENGTH:  cfg_d.stored_length  = cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // The generator reloads in the cycle after the write, once the new seed is in place.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= '0;
      restart_q <= 1'b0;
    end else begin
      cfg_q     <= cfg_d;
      restart_q <= cfg_we_i;
    end
  end

  smx_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .restart_i (cfg_we_i),
    .in_i      (in_i),
    .full_i    (full),
    .push_o    (push),
    .tag_o     (tag_in)
  );

  smx_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tag_i   (tag_in),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (tag_head)
  );

  smx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .restart_i    (restart_q),
    .head_valid_i (!empty),
    .head_i       (tag_head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

/* test/tb_splitmix64_xor_stream_decoder.sv */
// Testbench for the SplitMix64 keystream XOR stream decoder.
// Drives bytes through the smx_in_if/smx_out_if channels under random stalls and checks each
// result against a scoreboard that predicts it. Depends on smx_pkg, smx_ifs and the decoder.

// Predicts decoded results from the accepted bytes and checks what the block returns.
class decode_scoreboard;

  typedef struct {
    logic [7:0]      out_byte;
    logic            blob_end;
    smx_pkg::status_e status;
  } decoded_t;

  localparam int unsigned MaxShown = 40;

  // Shadow copy of the configuration registers.
  logic [63:0] key_seed;
  logic        encrypted;
  logic [31:0] blob_len;
  logic [31:0] stored_len;

  // Shadow copy of the generator.
  logic [63:0] gen_state;
  logic [63:0] key_word;
  logic [31:0] byte_pos;

  decoded_t    decoded_q[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned status_seen[4];

  function new();
    key_seed   = '0;
    encrypted  = 1'b0;
    blob_len   = '0;
    stored_len = '0;
    key_word   = '0;
    errors     = 0;
    checked    = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    restart_blob();
  endfunction

  function void restart_blob();
    byte_pos  = '0;
    gen_state = key_seed;
  endfunction

  function logic [63:0] mix_word(input logic [63:0] z);
    z = (z ^ (z >> smx_pkg::SM_SHIFT_1)) * smx_pkg::SM_MUL_A;
    z = (z ^ (z >> smx_pkg::SM_SHIFT_2)) * smx_pkg::SM_MUL_B;
    return z ^ (z >> smx_pkg::SM_SHIFT_3);
  endfunction

  function void write_reg(input smx_pkg::cfg_idx_e idx, input logic [63:0] data);
    case (idx)
      smx_pkg::CFG_KEY_SEED:       key_seed   = data;
      smx_pkg::CFG_ENCRYPTED_MODE: encrypted  = data[0];
      smx_pkg::CFG_BLOB_LENGTH:    blob_len   = data[31:0];
      smx_pkg::CFG_STORED_LENGTH:  stored_len = data[31:0];
      default: return;
    endcase
    restart_blob();
  endfunction

  // Works out the result for one accepted byte and queues it.
  function void decode_byte(input logic [7:0] in_byte);
    decoded_t    res;
    logic [2:0]  lane;
    logic [63:0] shifted;
    if (stored_len < blob_len) begin
      res.status = smx_pkg::ST_TRUNCATED;
    end else if (encrypted && key_seed == '0) begin
      res.status = smx_pkg::ST_KEY_MISSING;
    end else if (blob_len == '0) begin
      res.status = smx_pkg::ST_EMPTY;
    end else begin
      res.status = smx_pkg::ST_OK;
    end
    res.out_byte = '0;
    if (blob_len == '0) begin
      restart_blob();
      res.blob_end = 1'b1;
    end else begin
      lane = byte_pos[2:0];
      if (lane == 3'd0) begin
        gen_state = gen_state + smx_pkg::SM_INCREMENT;
        key_word  = mix_word(gen_state);
      end
      if (res.status == smx_pkg::ST_OK) begin
        shifted      = key_word >> (8 * lane);
        res.out_byte = encrypted ? (in_byte ^ shifted[7:0]) : in_byte;
      end
      res.blob_end = ({1'b0, byte_pos} + 33'd1 >= {1'b0, blob_len});
      if (res.blob_end) begin
        restart_blob();
      end else begin
        byte_pos = byte_pos + 32'd1;
      end
    end
    decoded_q.push_back(res);
  endfunction

  task report(input string msg);
    errors++;
    if (errors <= MaxShown) $display("MISMATCH: %s", msg);
  endtask

  task check_result(input logic [7:0] out_byte, input logic blob_end, input logic [1:0] status);
    decoded_t exp_res;
    if (decoded_q.size() == 0) begin
      report($sformatf("result %0d arrived with nothing expected (byte %02h)", checked,
                       out_byte));
    end else begin
      exp_res = decoded_q.pop_front();
      if (out_byte !== exp_res.out_byte)
        report($sformatf("result %0d: out_byte %02h, expected %02h", checked, out_byte,
                         exp_res.out_byte));
      if (blob_end !== exp_res.blob_end)
        report($sformatf("result %0d: blob_end %0b, expected %0b", checked, blob_end,
                         exp_res.blob_end));
      if (status !== exp_res.status)
        report($sformatf("result %0d: status %0d, expected %0d", checked, status,
                         exp_res.status));
      status_seen[exp_res.status]++;
    end
    checked++;
  endtask

  function int pending();
    return decoded_q.size();
  endfunction

endclass

module tb_splitmix64_xor_stream_decoder;

  localparam int unsigned ItemTarget = 1250;
  localparam int unsigned CycleLimit = 600000;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [smx_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [smx_pkg::CFG_DATA_W-1:0] cfg_wdata;

  smx_in_if  in_if ();
  smx_out_if out_if ();

  splitmix64_xor_stream_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  decode_scoreboard sb = new();

  bit          steady;
  int unsigned out_stall;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned settings_used;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    in_if.valid    = 1'b0;
    in_if.in_byte  = '0;
    out_if.ready   = 1'b0;
    steady         = 1'b0;
    out_stall      = 0;
    cycle_count    = 0;
    bytes_sent     = 0;
    settings_used  = 0;
  end

  // The receiver holds ready low for a random number of cycles after each transaction.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_stall == 0) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        out_stall--;
      end
    end
  end

  // Input transactions are noted before results are checked, so a purely combinational path is fine.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.decode_byte(in_if.in_byte);
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.out_byte, out_if.blob_end, out_if.status);
        out_stall = steady ? 0 : $urandom_range(0, 5);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               sb.pending());
      $display("** splitmix64_xor_stream_decoder: FAILED **");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] data);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= data;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    bytes_sent++;
  endtask

  // Stops sending and waits until every queued result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input smx_pkg::cfg_idx_e idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Unused upper bits of the narrow registers carry noise, which the block must drop.
  task automatic program_decoder(input logic [63:0] seed, input logic enc,
                                 input logic [31:0] blen, input logic [31:0] slen);
    wait_drained();
    write_reg(smx_pkg::CFG_KEY_SEED, seed);
    write_reg(smx_pkg::CFG_ENCRYPTED_MODE, {$urandom, 31'($urandom), enc});
    write_reg(smx_pkg::CFG_BLOB_LENGTH, {$urandom, blen});
    write_reg(smx_pkg::CFG_STORED_LENGTH, {$urandom, slen});
    @(negedge clk_i);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 199) == 0) wait_drained();
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_setting();
    logic [63:0] seed;
    logic        enc;
    logic [31:0] blen;
    logic [31:0] slen;
    int unsigned count;
    case ($urandom_range(0, 7))
      0:       seed = '0;
      1:       seed = '1;
      default: seed = {$urandom, $urandom};
    endcase
    enc = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 9))
      0:       blen = '0;
      1:       blen = $urandom;
      2:       blen = '1;
      default: blen = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 5))
      0:       slen = (blen == '0) ? '0 : ($urandom % blen);
      1:       slen = '1;
      2:       slen = $urandom;
      default: slen = (blen > 32'hFFFF_FFEF) ? blen : blen + $urandom_range(0, 16);
    endcase
    if (blen != '0 && blen <= 40) begin
      count = blen * $urandom_range(1, 4) + $urandom_range(0, 3);
      if (count > 90) count = 90;
    end else begin
      count = $urandom_range(5, 40);
    end
    steady = ($urandom_range(0, 4) == 0);
    program_decoder(seed, enc, blen, slen);
    send_random(count);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Plain mode passes bytes through; the third byte closes the blob.
    program_decoder(64'h0, 1'b0, 32'd3, 32'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);

    // Encrypted blob of nine bytes: crosses into a second keystream word, then restarts.
    program_decoder(64'h0123_4567_89AB_CDEF, 1'b1, 32'd9, 32'd9);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h5A);
    send_byte(8'hC3);
    wait_drained();
    repeat (6) send_byte(8'($urandom_range(0, 255)));

    // Stored length below blob length; truncation also beats a missing key.
    program_decoder(64'h0, 1'b1, 32'd4, 32'd3);
    send_byte(8'h81);
    send_byte(8'h7E);

    // Encryption requested with a zero seed.
    program_decoder(64'h0, 1'b1, 32'd5, 32'd5);
    send_byte(8'hFF);
    send_byte(8'h01);

    // Empty blob, then an empty blob where the missing key takes priority.
    program_decoder(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'd0, 32'd0);
    send_byte(8'hFF);
    send_byte(8'h00);
    program_decoder(64'h0, 1'b1, 32'd0, 32'hFFFF_FFFF);
    send_byte(8'h3C);

    // Largest seed and lengths.
    program_decoder(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (4) send_byte(8'($urandom_range(0, 255)));

    while (bytes_sent < ItemTarget) random_setting();

    steady = 1'b0;
    wait_drained();
    repeat (40) @(posedge clk_i);

    $display("Covered %0d register settings and %0d bytes, %0d results checked.",
             settings_used, bytes_sent, sb.checked);
    $display("Results by status: ok %0d, truncated %0d, key missing %0d, empty %0d.",
             sb.status_seen[smx_pkg::ST_OK], sb.status_seen[smx_pkg::ST_TRUNCATED],
             sb.status_seen[smx_pkg::ST_KEY_MISSING], sb.status_seen[smx_pkg::ST_EMPTY]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** splitmix64_xor_stream_decoder: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
      $display("** splitmix64_xor_stream_decoder: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/smx_pkg.sv
rtl/core/smx_ifs.sv
rtl/core/smx_front.sv
rtl/core/smx_queue.sv
rtl/core/smx_mix.sv
rtl/core/smx_back.sv
rtl/core/splitmix64_xor_stream_decoder.sv
test/tb_splitmix64_xor_stream_decoder.sv
